FILE: rtl/core/wpt_pkg.sv
// ----------------------------------------------------------------------------
// wpt_pkg: shared types and constants of the windowed percentile tracker
// Ring geometry, field widths, operation and register codes, entry layout.
// ----------------------------------------------------------------------------
package wpt_pkg;

  localparam int RING_DEPTH = 128;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int PCT_W      = 7;
  localparam int TIME_W     = 32;
  localparam int VAL_W      = 40;
  localparam int SERIES_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // divide by 100 as (x * DIV_MULT) >> DIV_SHIFT, exact for x < 2^23
  localparam int X_W       = PCT_W + CNT_W;
  localparam int DIV_SHIFT = 30;
  localparam int MULT_W    = 24;
  localparam logic [MULT_W-1:0] DIV_MULT = 24'd10737419;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_TICK  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PCT_LOW  = 3'd0,
    CFG_PCT_MID  = 3'd1,
    CFG_PCT_HIGH = 3'd2,
    CFG_AGING_ON = 3'd3,
    CFG_MAX_AGE  = 3'd4
  } cfg_idx_e;

  typedef enum logic [SERIES_W-1:0] {
    SER_WORK     = 3'd0,
    SER_NET      = 3'd1,
    SER_SCRIPT   = 3'd2,
    SER_MEM      = 3'd3,
    SER_REAL_MEM = 3'd4
  } series_e;

  typedef enum logic [3:0] {
    SEL_IDLE,
    SEL_COUNT,
    SEL_MUL,
    SEL_DIV,
    SEL_CLAMP,
    SEL_CAND_RD,
    SEL_CAND_CHK,
    SEL_SCAN,
    SEL_MATCH,
    SEL_EMIT
  } sel_state_e;

  typedef struct packed {
    logic [TIME_W-1:0] work;
    logic [TIME_W-1:0] net;
    logic [TIME_W-1:0] script;
    logic [VAL_W-1:0]  mem;
    logic [VAL_W-1:0]  real_mem;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [PCT_W-1:0]  pct_low;
    logic [PCT_W-1:0]  pct_mid;
    logic [PCT_W-1:0]  pct_high;
    logic              aging_on;
    logic [TIME_W-1:0] max_age;
  } cfg_t;

  typedef struct packed {
    series_e          series;
    logic [VAL_W-1:0] value_low;
    logic [VAL_W-1:0] value_mid;
    logic [VAL_W-1:0] value_high;
    logic             last;
  } result_t;

  function automatic logic [VAL_W-1:0] series_val(entry_t e, series_e s);
    logic [VAL_W-1:0] v;
    case (s)
      SER_WORK:     v = {{(VAL_W-TIME_W){1'b0}}, e.work};
      SER_NET:      v = {{(VAL_W-TIME_W){1'b0}}, e.net};
      SER_SCRIPT:   v = {{(VAL_W-TIME_W){1'b0}}, e.script};
      SER_MEM:      v = e.mem;
      default:      v = e.real_mem;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/windowed_percentile_tracker.sv
// ----------------------------------------------------------------------------
// windowed_percentile_tracker: sliding-window percentile selection
// Sample ring with tick stamps; queries report three percentiles per series.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o): op 0 adds a sample, op 1 advances
//    the tick, op 2 starts a query, op 3 is ignored. A transfer completes when
//    in_valid_i is high and in_stall_o is low.
//  - Add and tick never stall; one may follow in every cycle while no query runs.
//  - A query yields five results (working, net, script, memory, real memory),
//    the fifth flagged by last_o. Per series the engine counts eligible samples
//    in one ring pass, computes ranks (multiply, divide, clamp), reads each
//    slot as a candidate, and for each eligible candidate runs another ring
//    pass. The passes run one after another, as the ring memory has a single
//    read port. in_stall_o is high meanwhile.
//  - Output channel (out_valid_o / out_stall_i): one result register; while the
//    receiver stalls, the result holds and the engine waits before the next one.
//  - Config port: cfg_ready_o is always high; write only while idle.
//  - Reset clears the per-slot valid bits at once (no clearing pass), the
//    tick, the write slot and loads the register defaults.
module windowed_percentile_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [31:0]                   script_us_i,
  input  logic [31:0]                   net_us_i,
  input  logic [39:0]                   mem_bytes_i,
  input  logic [39:0]                   real_mem_bytes_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    series_o,
  output logic [39:0]                   value_low_o,
  output logic [39:0]                   value_mid_o,
  output logic [39:0]                   value_high_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wpt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wpt_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wpt_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [TIME_W-1:0] tick_q, tick_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;

  logic       in_xfer, busy, emit, emit_ack, start, wr_en, rd_en, rd_valid;
  op_e        op;
  logic [TIME_W:0]  work_sum;
  entry_t     wr_data, rd_data;
  logic [IDX_W-1:0] rd_addr;
  result_t    result;

  assign op      = op_e'(op_i);
  assign in_xfer = in_valid_i && !in_stall_o;
  assign in_stall_o = busy;
  assign wr_en   = in_xfer && (op == OP_ADD);
  assign start   = in_xfer && (op == OP_QUERY);

  // working time saturates at 32 bits
  assign work_sum         = {1'b0, script_us_i} + {1'b0, net_us_i};
  assign wr_data.work     = work_sum[TIME_W] ? '1 : work_sum[TIME_W-1:0];
  assign wr_data.net      = net_us_i;
  assign wr_data.script   = script_us_i;
  assign wr_data.mem      = mem_bytes_i;
  assign wr_data.real_mem = real_mem_bytes_i;
  assign wr_data.stamp    = tick_q;

  always_comb begin
    slot_d = slot_q;
    tick_d = tick_q;
    if (wr_en) slot_d = (slot_q == IDX_W'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
    if (in_xfer && (op == OP_TICK)) tick_d = tick_q + 1'b1;
  end

  // config writes; unknown indexes fall through
  assign cfg_ready_o = 1'b1;
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PCT_LOW:  cfg_d.pct_low  = cfg_data_i[PCT_W-1:0];
        CFG_PCT_MID:  cfg_d.pct_mid  = cfg_data_i[PCT_W-1:0];
        CFG_PCT_HIGH: cfg_d.pct_high = cfg_data_i[PCT_W-1:0];
        CFG_AGING_ON: cfg_d.aging_on = cfg_data_i[0];
        CFG_MAX_AGE:  cfg_d.max_age  = cfg_data_i[TIME_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  // output register: loads when empty or when its result transfers
  assign emit_ack    = emit && (!out_valid_q || !out_stall_i);
  assign out_valid_d = emit_ack || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pct_low  <= PCT_W'(50);
      cfg_q.pct_mid  <= PCT_W'(95);
      cfg_q.pct_high <= PCT_W'(99);
      cfg_q.aging_on <= 1'b1;
      cfg_q.max_age  <= TIME_W'(60000);
      slot_q         <= '0;
      tick_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      slot_q      <= slot_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ack) out_q <= result;
  end

  wpt_ring_mem u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (slot_q),
    .wr_data_i  (wr_data),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .rd_valid_o (rd_valid)
  );

  wpt_select u_sel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .cfg_i      (cfg_q),
    .tick_i     (tick_q),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .rd_valid_i (rd_valid),
    .busy_o     (busy),
    .emit_o     (emit),
    .emit_ack_i (emit_ack),
    .result_o   (result)
  );

  assign out_valid_o  = out_valid_q;
  assign series_o     = out_q.series;
  assign value_low_o  = out_q.value_low;
  assign value_mid_o  = out_q.value_mid;
  assign value_high_o = out_q.value_high;
  assign last_o       = out_q.last;

`ifndef NO_ASSERTIONS
  // a query stalls the input side in the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> in_stall_o) else $error("query did not stall input");
  // last flag marks the real memory series only
  a_last_series: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (series_o == SER_REAL_MEM)))
    else $error("last flag on wrong series");
  // after a non-final result transfers, the query is still running unless
  // the final result has just been loaded behind it
  a_mid_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=>
    (in_stall_o || (out_valid_o && last_o)))
    else $error("query ended early");
`endif

endmodule

FILE: rtl/core/wpt_ring_mem.sv
// ----------------------------------------------------------------------------
// wpt_ring_mem: sample ring storage
// One write port, one registered read port, per-entry valid bits cleared by reset.
// ----------------------------------------------------------------------------
module wpt_ring_mem (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [wpt_pkg::IDX_W-1:0] wr_addr_i,
  input  wpt_pkg::entry_t       wr_data_i,
  input  logic                  rd_en_i,
  input  logic [wpt_pkg::IDX_W-1:0] rd_addr_i,
  output wpt_pkg::entry_t       rd_data_o,
  output logic                  rd_valid_o
);
  import wpt_pkg::*;

  entry_t                mem_q [RING_DEPTH];
  entry_t                rd_data_q;
  logic [RING_DEPTH-1:0] vld_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

endmodule

FILE: rtl/core/wpt_select.sv
// ----------------------------------------------------------------------------
// wpt_select: percentile selection sequencer
// Counts eligible samples, then ranks each candidate by a full ring scan.
// ----------------------------------------------------------------------------
module wpt_select (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  wpt_pkg::cfg_t              cfg_i,
  input  logic [wpt_pkg::TIME_W-1:0] tick_i,
  output logic                       rd_en_o,
  output logic [wpt_pkg::IDX_W-1:0]  rd_addr_o,
  input  wpt_pkg::entry_t            rd_data_i,
  input  logic                       rd_valid_i,
  output logic                       busy_o,
  output logic                       emit_o,
  input  logic                       emit_ack_i,
  output wpt_pkg::result_t           result_o
);
  import wpt_pkg::*;

  sel_state_e       state_q, state_d;
  series_e          s_q, s_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] a_q, a_d;
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] n_q, n_d, lt_q, lt_d, le_q, le_d;
  logic [VAL_W-1:0] cand_q, cand_d;
  logic [X_W-1:0]   x_q [3];
  logic [X_W-1:0]   x_d [3];
  logic [CNT_W:0]   qt_q [3];
  logic [CNT_W:0]   qt_d [3];
  logic [CNT_W-1:0] r_q [3];
  logic [CNT_W-1:0] r_d [3];
  logic [VAL_W-1:0] res_q [3];
  logic [VAL_W-1:0] res_d [3];

  logic [PCT_W-1:0]  pct [3];
  logic [VAL_W-1:0]  val;
  logic [TIME_W-1:0] age;
  logic              elig, stream_rd, stream_done, last_i;
  logic [X_W+MULT_W-1:0] prod [3];

  assign pct[0] = cfg_i.pct_low;
  assign pct[1] = cfg_i.pct_mid;
  assign pct[2] = cfg_i.pct_high;

  assign val  = series_val(rd_data_i, s_q);
  assign age  = tick_i - rd_data_i.stamp;
  assign elig = rd_valid_i && (val != '0) && !(cfg_i.aging_on && (age > cfg_i.max_age));

  assign stream_rd   = ((state_q == SEL_COUNT) || (state_q == SEL_SCAN)) &&
                       (a_q < CNT_W'(RING_DEPTH));
  assign stream_done = !stream_rd && !pend_q;
  assign last_i      = (i_q == IDX_W'(RING_DEPTH - 1));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = {{MULT_W{1'b0}}, x_q[k]} * {{X_W{1'b0}}, DIV_MULT};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SEL_IDLE:     if (start_i) state_d = SEL_COUNT;
      SEL_COUNT:    if (stream_done) state_d = SEL_MUL;
      SEL_MUL:      state_d = SEL_DIV;
      SEL_DIV:      state_d = SEL_CLAMP;
      SEL_CLAMP:    state_d = (n_q == '0) ? SEL_EMIT : SEL_CAND_RD;
      SEL_CAND_RD:  state_d = SEL_CAND_CHK;
      SEL_CAND_CHK: begin
        if (elig) state_d = SEL_SCAN;
        else if (last_i) state_d = SEL_EMIT;
        else state_d = SEL_CAND_RD;
      end
      SEL_SCAN:     if (stream_done) state_d = SEL_MATCH;
      SEL_MATCH:    state_d = last_i ? SEL_EMIT : SEL_CAND_RD;
      SEL_EMIT: begin
        if (emit_ack_i) state_d = (s_q == SER_REAL_MEM) ? SEL_IDLE : SEL_COUNT;
      end
      default:      state_d = SEL_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rd_en_o   = 1'b0;
    rd_addr_o = a_q[IDX_W-1:0];
    case (state_q)
      SEL_COUNT, SEL_SCAN: rd_en_o = stream_rd;
      SEL_CAND_RD: begin
        rd_en_o   = 1'b1;
        rd_addr_o = i_q;
      end
      default: rd_en_o = 1'b0;
    endcase
  end

  assign busy_o = (state_q != SEL_IDLE);
  assign emit_o = (state_q == SEL_EMIT);
  assign result_o.series     = s_q;
  assign result_o.value_low  = res_q[0];
  assign result_o.value_mid  = res_q[1];
  assign result_o.value_high = res_q[2];
  assign result_o.last       = (s_q == SER_REAL_MEM);

  // datapath
  always_comb begin
    s_d    = s_q;
    i_d    = i_q;
    a_d    = a_q;
    pend_d = stream_rd;
    n_d    = n_q;
    lt_d   = lt_q;
    le_d   = le_q;
    cand_d = cand_q;
    x_d    = x_q;
    qt_d   = qt_q;
    r_d    = r_q;
    res_d  = res_q;
    if (stream_rd) a_d = a_q + 1'b1;
    case (state_q)
      SEL_IDLE: begin
        s_d = SER_WORK;
        a_d = '0;
        n_d = '0;
      end
      SEL_COUNT: if (pend_q && elig) n_d = n_q + 1'b1;
      SEL_MUL: begin
        for (int k = 0; k < 3; k++) x_d[k] = X_W'(pct[k] * n_q);
      end
      SEL_DIV: begin
        for (int k = 0; k < 3; k++) qt_d[k] = prod[k][DIV_SHIFT +: CNT_W+1];
      end
      SEL_CLAMP: begin
        i_d = '0;
        for (int k = 0; k < 3; k++) begin
          r_d[k]   = (qt_q[k] >= {1'b0, n_q}) ? n_q - 1'b1 : qt_q[k][CNT_W-1:0];
          res_d[k] = '0;
        end
      end
      SEL_CAND_CHK: begin
        if (elig) begin
          cand_d = val;
          a_d    = '0;
          lt_d   = '0;
          le_d   = '0;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      SEL_SCAN: begin
        if (pend_q && elig) begin
          lt_d = lt_q + CNT_W'(val < cand_q);
          le_d = le_q + CNT_W'(val <= cand_q);
        end
      end
      SEL_MATCH: begin
        i_d = i_q + 1'b1;
        for (int k = 0; k < 3; k++) begin
          if ((lt_q <= r_q[k]) && (r_q[k] < le_q)) res_d[k] = cand_q;
        end
      end
      SEL_EMIT: begin
        if (emit_ack_i) begin
          s_d = series_e'(s_q + 3'd1);
          a_d = '0;
          n_d = '0;
        end
      end
      default: s_d = s_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEL_IDLE;
      s_q     <= SER_WORK;
      i_q     <= '0;
      a_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      s_q     <= s_d;
      i_q     <= i_d;
      a_q     <= a_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    lt_q   <= lt_d;
    le_q   <= le_d;
    cand_q <= cand_d;
    x_q    <= x_d;
    qt_q   <= qt_d;
    r_q    <= r_d;
    res_q  <= res_d;
  end

endmodule

FILE: bench/tb_windowed_percentile_tracker.sv
// ----------------------------------------------------------------------------
// tb_windowed_percentile_tracker: self-checking bench for the percentile tracker
// Drives adds, ticks and queries with random idling on both channels, predicts
// every query result from a behavioral copy of the ring and compares in order.
// ----------------------------------------------------------------------------
module tb_windowed_percentile_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import wpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct {
    logic [SERIES_W-1:0] series;
    logic [VAL_W-1:0]    v_low;
    logic [VAL_W-1:0]    v_mid;
    logic [VAL_W-1:0]    v_high;
    logic                last;
  } pct_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] op_i = '0;
  logic [31:0] script_us_i = '0;
  logic [31:0] net_us_i = '0;
  logic [39:0] mem_bytes_i = '0;
  logic [39:0] real_mem_bytes_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] series_o;
  logic [39:0] value_low_o, value_mid_o, value_high_o;
  logic last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  windowed_percentile_tracker uut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // idling odds in percent, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;

  // behavioral copy of the block
  logic [TIME_W-1:0] ring_work [RING_DEPTH];
  logic [TIME_W-1:0] ring_net [RING_DEPTH];
  logic [TIME_W-1:0] ring_script [RING_DEPTH];
  logic [VAL_W-1:0]  ring_mem [RING_DEPTH];
  logic [VAL_W-1:0]  ring_rmem [RING_DEPTH];
  logic [TIME_W-1:0] ring_stamp [RING_DEPTH];
  int unsigned       next_slot = 0;
  logic [TIME_W-1:0] now_tick = '0;
  logic [PCT_W-1:0]  shadow_pct[3] = '{7'd50, 7'd95, 7'd99};
  logic              shadow_aging = 1'b1;
  logic [TIME_W-1:0] shadow_max_age = 32'd60000;

  pct_result_t pending_results[$];

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_work[i] = '0; ring_net[i] = '0; ring_script[i] = '0;
      ring_mem[i] = '0; ring_rmem[i] = '0; ring_stamp[i] = '0;
    end
  end

  function automatic logic [VAL_W-1:0] sample_of(int s, int i);
    case (s)
      SER_WORK:   return {8'd0, ring_work[i]};
      SER_NET:    return {8'd0, ring_net[i]};
      SER_SCRIPT: return {8'd0, ring_script[i]};
      SER_MEM:    return ring_mem[i];
      default:    return ring_rmem[i];
    endcase
  endfunction

  // sorted eligible samples of one series, then rank selection per percentile
  function automatic pct_result_t select_series(int s);
    logic [VAL_W-1:0] sorted [RING_DEPTH];
    logic [VAL_W-1:0] v;
    logic [TIME_W-1:0] age;
    pct_result_t res;
    int n, j, r;
    n = 0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      v = sample_of(s, i);
      age = now_tick - ring_stamp[i];
      if (v == '0) continue;                       // zero never counts
      if (shadow_aging && age > shadow_max_age) continue;
      j = n;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
      n++;
    end
    res.series = s[SERIES_W-1:0];
    res.last = (s == SER_REAL_MEM);
    for (int k = 0; k < 3; k++) begin
      if (n == 0) v = '0;
      else begin
        r = (int'(shadow_pct[k]) * n) / 100;
        if (r >= n) r = n - 1;                      // rank past end
        v = sorted[r];
      end
      case (k)
        0: res.v_low = v;
        1: res.v_mid = v;
        default: res.v_high = v;
      endcase
    end
    return res;
  endfunction

  task automatic track_item(logic [1:0] op, logic [31:0] sc, logic [31:0] nt,
                            logic [39:0] mem, logic [39:0] rmem);
    logic [32:0] wsum;
    case (op_e'(op))
      OP_ADD: begin
        wsum = {1'b0, sc} + {1'b0, nt};
        ring_work[next_slot] = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
        ring_net[next_slot] = nt;
        ring_script[next_slot] = sc;
        ring_mem[next_slot] = mem;
        ring_rmem[next_slot] = rmem;
        ring_stamp[next_slot] = now_tick;
        next_slot = (next_slot + 1) % RING_DEPTH;
      end
      OP_TICK: now_tick = now_tick + 1;
      OP_QUERY: for (int s = 0; s < 5; s++) pending_results.push_back(select_series(s));
      default: ;
    endcase
  endtask

  // one input transfer; valid stays high after acceptance for a back-to-back item
  task automatic send_item(logic [1:0] op, logic [31:0] sc, logic [31:0] nt,
                           logic [39:0] mem, logic [39:0] rmem);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    script_us_i <= sc;
    net_us_i <= nt;
    mem_bytes_i <= mem;
    real_mem_bytes_i <= rmem;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    track_item(op, sc, nt, mem, rmem);
  endtask

  // lower valid and let every outstanding result arrive
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    case (idx)
      CFG_PCT_LOW:  shadow_pct[0] = data[PCT_W-1:0];
      CFG_PCT_MID:  shadow_pct[1] = data[PCT_W-1:0];
      CFG_PCT_HIGH: shadow_pct[2] = data[PCT_W-1:0];
      CFG_AGING_ON: shadow_aging = data[0];
      default:      shadow_max_age = data;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_pcts(logic [6:0] lo, logic [6:0] mid, logic [6:0] hi);
    write_reg(CFG_PCT_LOW, {25'd0, lo});
    write_reg(CFG_PCT_MID, {25'd0, mid});
    write_reg(CFG_PCT_HIGH, {25'd0, hi});
  endtask

  function automatic logic [31:0] rand_time();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom_range(20, 1);        // small values give duplicates
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [39:0] rand_mem();
    case ($urandom_range(9))
      0: return '0;
      1: return 40'hFF_FFFF_FFFF;
      2, 3: return $urandom_range(20, 1);
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic add_random();
    send_item(OP_ADD, rand_time(), rand_time(), rand_mem(), rand_mem());
  endtask

  task automatic send_ctl(op_e op);
    send_item(op, $urandom, $urandom, {8'($urandom), 32'($urandom)}, 40'd0);
  endtask

  // ---------------------------------------------------------------- directed
  task automatic test_empty_ring();
    send_ctl(OP_QUERY);                          // nothing stored: all zeros
  endtask

  task automatic test_field_extremes();
    send_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
    send_item(OP_ADD, 32'h0, 32'h0, 40'h0, 40'h0);   // zero sample ignored
    send_item(OP_ADD, 32'h8000_0000, 32'h8000_0000, 40'h1, 40'h80_0000_0000);
    send_item(OP_ADD, 32'd3, 32'd0, 40'd7, 40'd7);
    send_ctl(OP_NONE);                           // unused op does nothing
    send_ctl(OP_QUERY);
  endtask

  task automatic test_percentile_corners();
    set_pcts(7'd0, 7'd100, 7'd127);              // rank zero and rank past end
    for (int i = 0; i < 5; i++) add_random();
    send_ctl(OP_QUERY);
    set_pcts(7'd99, 7'd1, 7'd64);
    send_ctl(OP_QUERY);
  endtask

  task automatic test_aging();
    write_reg(CFG_MAX_AGE, 32'd0);               // only current tick survives
    send_ctl(OP_TICK);
    add_random();
    add_random();
    send_ctl(OP_QUERY);
    write_reg(CFG_MAX_AGE, 32'd1);
    send_ctl(OP_TICK);
    add_random();
    send_ctl(OP_TICK);
    send_ctl(OP_QUERY);
    write_reg(CFG_AGING_ON, 32'd0);              // keep everything
    send_ctl(OP_QUERY);
    write_reg(CFG_AGING_ON, 32'd1);
  endtask

  // ---------------------------------------------------------------- random
  task automatic test_random_mix(int count, int query_pct, int tick_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < query_pct) send_ctl(OP_QUERY);
      else if (r < query_pct + tick_pct) send_ctl(OP_TICK);
      else if (r < query_pct + tick_pct + 3) send_ctl(OP_NONE);
      else add_random();
    end
  endtask

  // receiver stall, redrawn every cycle
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  // result checker
  always @(posedge clk_i) begin
    pct_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result series=%0d", $time, series_o);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (series_o !== exp_r.series || value_low_o !== exp_r.v_low ||
            value_mid_o !== exp_r.v_mid || value_high_o !== exp_r.v_high ||
            last_o !== exp_r.last) begin
          $display("%0t: mismatch expected ser=%0d lo=%h mid=%h hi=%h last=%b",
                   $time, exp_r.series, exp_r.v_low, exp_r.v_mid, exp_r.v_high,
                   exp_r.last);
          $display("%0t:          actual   ser=%0d lo=%h mid=%h hi=%h last=%b",
                   $time, series_o, value_low_o, value_mid_o, value_high_o, last_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_ring();
    test_field_extremes();
    test_percentile_corners();
    test_aging();

    // receiver idles more, short window keeps queries cheap
    send_idle_pct = 38; recv_idle_pct = 53;
    write_reg(CFG_MAX_AGE, 32'd3);
    set_pcts(7'd50, 7'd95, 7'd99);
    test_random_mix(120, 9, 30);

    // sender idles more, random percentiles
    send_idle_pct = 53; recv_idle_pct = 38;
    set_pcts(7'($urandom), 7'($urandom), 7'($urandom));
    write_reg(CFG_MAX_AGE, 32'd1);
    test_random_mix(120, 9, 35);

    // no idling; unlimited window, so queries walk the full ring: keep them rare
    send_idle_pct = 0; recv_idle_pct = 0;
    set_pcts(7'd17, 7'd65, 7'd99);
    write_reg(CFG_MAX_AGE, 32'hFFFF_FFFF);
    test_random_mix(80, 3, 20);
    send_ctl(OP_QUERY);

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
